// File: design/longest_prefix_match_router_core_assert.svh
// Assertion macros used by the checker of the route table block.
`ifndef LONGEST_PREFIX_MATCH_ROUTER_CORE_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_ROUTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LPMR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPMR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/lpmr_pkg.sv
`default_nettype none

package lpmr_pkg;

   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 6;
   localparam int IF_W     = 3;
   localparam int TTL_W    = 8;
   localparam int STATUS_W = 3;

   localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_ROUTE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_FORWARDED = 3'd0,
      STATUS_TTL_DROP  = 3'd1,
      STATUS_NO_ROUTE  = 3'd2,
      STATUS_ADDED     = 3'd3,
      STATUS_DUPLICATE = 3'd4,
      STATUS_FULL      = 3'd5
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  length;
      logic [IF_W-1:0]   iface;
      logic [ADDR_W-1:0] gateway;
      logic              direct;
   } route_entry_type;

   // Mask with the leading len bits set; len is already limited to 32.
   function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      logic [2*ADDR_W-1:0] shifted;
      shifted = {{ADDR_W{1'b1}}, {ADDR_W{1'b0}}} >> len;
      return ~shifted[2*ADDR_W-1:ADDR_W];
   endfunction

endpackage

`default_nettype wire

// File: design/longest_prefix_match_router_core.sv
`default_nettype none

// IPv4 route table with longest-prefix lookup. A word is taken when start is high and
// busy is low; its single result appears on the rsp_ ports for exactly one cycle with
// rsp_strobe high, and the receiver cannot stall it, so it must take every result as it
// comes. Add and route both scan the stored routes one entry per cycle through the single
// read port of the route memory; for a route with a TTL of 0 or 1, or any word while the
// table is empty, the scan is skipped and the result is made in the finish state.
// busy falls in the cycle the result is shown, so the next word may be taken at that edge.
// Routes fill the table from slot 0 upward and are never removed, so a fill count stands
// for the valid bits and reset empties the table at once.
module longest_prefix_match_router_core
   import lpmr_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_operation,
   input  wire logic [ADDR_W-1:0]   req_key_address,
   input  wire logic [LEN_W-1:0]    req_prefix_length,
   input  wire logic                req_has_next_hop,
   input  wire logic [ADDR_W-1:0]   req_next_hop_address,
   input  wire logic [IF_W-1:0]     req_interface_index,
   input  wire logic [TTL_W-1:0]    req_time_to_live,
   output logic                     rsp_strobe,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [IF_W-1:0]          rsp_out_interface,
   output logic [ADDR_W-1:0]        rsp_out_next_hop,
   output logic [TTL_W-1:0]         rsp_ttl_out
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   route_entry_type table_mem [TABLE_ENTRIES];
   route_entry_type rd_data_ff;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     rd_addr_ff, rd_addr_in;
   logic              issuing_ff, issuing_in;
   logic              rd_valid_ff, rd_last_ff;
   logic              hit_ff, hit_in;

   logic              op_ff;
   logic [TTL_W-1:0]  ttl_ff;
   route_entry_type   new_entry_ff, new_entry_in;
   logic [LEN_W-1:0]  best_len_ff, best_len_in;
   logic [IF_W-1:0]   best_iface_ff, best_iface_in;
   logic [ADDR_W-1:0] best_nh_ff, best_nh_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [IF_W-1:0]   rsp_iface_ff, rsp_iface_in;
   logic [ADDR_W-1:0] rsp_nh_ff, rsp_nh_in;
   logic [TTL_W-1:0]  rsp_ttl_ff, rsp_ttl_in;

   logic              accept;
   logic              last_issue;
   logic              table_full;
   logic              entry_match;
   logic              mem_we;
   logic [LEN_W-1:0]  req_len;
   logic [ADDR_W-1:0] cmp_mask;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign req_len    = (req_prefix_length > LEN_MAX) ? LEN_MAX : req_prefix_length;
   assign last_issue = (CW'(rd_addr_ff) == (count_ff - CW'(1)));
   assign table_full = (count_ff == CW'(TABLE_ENTRIES));

   // The one compare unit: prefix match on a route, exact prefix and length on an add.
   assign cmp_mask = len_mask(rd_data_ff.length);
   always_comb begin
      if (op_ff == OP_ROUTE) begin
         entry_match = ((new_entry_ff.prefix & cmp_mask) == rd_data_ff.prefix)
                       && (!hit_ff || (rd_data_ff.length > best_len_ff));
      end else begin
         entry_match = (rd_data_ff.prefix == new_entry_ff.prefix)
                       && (rd_data_ff.length == new_entry_ff.length);
      end
   end

   always_comb begin
      new_entry_in = new_entry_ff;
      if (accept) begin
         new_entry_in.length  = req_len;
         new_entry_in.iface   = req_interface_index;
         new_entry_in.gateway = req_next_hop_address;
         new_entry_in.direct  = !req_has_next_hop;
         // A route keeps the raw destination; an add keeps the masked prefix.
         if (req_operation == OP_ROUTE) begin
            new_entry_in.prefix = req_key_address;
         end else begin
            new_entry_in.prefix = req_key_address & len_mask(req_len);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      rd_addr_in    = rd_addr_ff;
      issuing_in    = issuing_ff;
      hit_in        = hit_ff;
      best_len_in   = best_len_ff;
      best_iface_in = best_iface_ff;
      best_nh_in    = best_nh_ff;
      count_in      = count_ff;
      mem_we        = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_iface_in  = rsp_iface_ff;
      rsp_nh_in     = rsp_nh_ff;
      rsp_ttl_in    = rsp_ttl_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hit_in     = 1'b0;
               rd_addr_in = '0;
               if (count_ff == '0
                   || (req_operation == OP_ROUTE && req_time_to_live < 8'd2)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in   = ST_SCAN;
                  issuing_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (issuing_ff) begin
               if (last_issue) begin
                  issuing_in = 1'b0;
               end else begin
                  rd_addr_in = rd_addr_ff + AW'(1);
               end
            end
            if (rd_valid_ff && entry_match) begin
               hit_in        = 1'b1;
               best_len_in   = rd_data_ff.length;
               best_iface_in = rd_data_ff.iface;
               best_nh_in    = rd_data_ff.direct ? new_entry_ff.prefix : rd_data_ff.gateway;
            end
            if (rd_valid_ff && rd_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_iface_in  = '0;
            rsp_nh_in     = '0;
            rsp_ttl_in    = '0;
            if (op_ff == OP_ROUTE) begin
               if (ttl_ff < 8'd2) begin
                  rsp_status_in = STATUS_TTL_DROP;
               end else if (hit_ff) begin
                  rsp_status_in = STATUS_FORWARDED;
                  rsp_iface_in  = best_iface_ff;
                  rsp_nh_in     = best_nh_ff;
                  rsp_ttl_in    = ttl_ff - 8'd1;
               end else begin
                  rsp_status_in = STATUS_NO_ROUTE;
               end
            end else begin
               if (hit_ff) begin
                  rsp_status_in = STATUS_DUPLICATE;
               end else if (table_full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  rsp_status_in = STATUS_ADDED;
                  mem_we        = 1'b1;
                  count_in      = count_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         issuing_ff    <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rd_last_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         issuing_ff    <= issuing_in;
         rd_valid_ff   <= issuing_ff;
         rd_last_ff    <= issuing_ff && last_issue;
         hit_ff        <= hit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      new_entry_ff  <= new_entry_in;
      best_len_ff   <= best_len_in;
      best_iface_ff <= best_iface_in;
      best_nh_ff    <= best_nh_in;
      rsp_status_ff <= rsp_status_in;
      rsp_iface_ff  <= rsp_iface_in;
      rsp_nh_ff     <= rsp_nh_in;
      rsp_ttl_ff    <= rsp_ttl_in;
      if (accept) begin
         op_ff  <= req_operation;
         ttl_ff <= req_time_to_live;
      end
   end

   // Route memory: one write port at the fill count, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[count_ff[AW-1:0]] <= new_entry_ff;
      end
      rd_data_ff <= table_mem[rd_addr_ff];
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_interface = rsp_iface_ff;
   assign rsp_out_next_hop  = rsp_nh_ff;
   assign rsp_ttl_out       = rsp_ttl_ff;

endmodule

`default_nettype wire

// File: design/lpmr_checker.sv
`default_nettype none

`include "longest_prefix_match_router_core_assert.svh"

module lpmr_checker
   import lpmr_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_strobe,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [IF_W-1:0]     rsp_out_interface,
   input wire logic [ADDR_W-1:0]   rsp_out_next_hop,
   input wire logic [TTL_W-1:0]    rsp_ttl_out
);

   `LPMR_ASSERT_NXT(a_accept_sets_busy, clock, reset, start && !busy, busy, "accept without busy")

   `LPMR_ASSERT_NXT(a_strobe_one_cycle, clock, reset, rsp_strobe, !rsp_strobe, "strobe held twice")

   `LPMR_ASSERT_IMP(a_strobe_frees, clock, reset, rsp_strobe, !busy, "busy during result")

   `LPMR_ASSERT_IMP(a_fields_zero, clock, reset, rsp_strobe && rsp_status != STATUS_FORWARDED, rsp_out_interface == '0 && rsp_out_next_hop == '0 && rsp_ttl_out == '0, "nonzero fields on non-forward result")

   `LPMR_ASSERT_IMP(a_fwd_ttl, clock, reset, rsp_strobe && rsp_status == STATUS_FORWARDED, rsp_ttl_out != '0, "forwarded word with zero TTL")

endmodule

bind longest_prefix_match_router_core lpmr_checker u_lpmr_checker (.*);

`default_nettype wire

// File: tb/longest_prefix_match_router_core_checker.sv
`default_nettype none

// Watches both channels of the route table, keeps its own copy of the table and checks
// every result word against the answer worked out when the request word was taken.
module longest_prefix_match_router_core_checker
   import lpmr_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire logic                req_operation,
   input  wire logic [ADDR_W-1:0]   req_key_address,
   input  wire logic [LEN_W-1:0]    req_prefix_length,
   input  wire logic                req_has_next_hop,
   input  wire logic [ADDR_W-1:0]   req_next_hop_address,
   input  wire logic [IF_W-1:0]     req_interface_index,
   input  wire logic [TTL_W-1:0]    req_time_to_live,
   input  wire logic                rsp_strobe,
   input  wire logic [STATUS_W-1:0] rsp_status,
   input  wire logic [IF_W-1:0]     rsp_out_interface,
   input  wire logic [ADDR_W-1:0]   rsp_out_next_hop,
   input  wire logic [TTL_W-1:0]    rsp_ttl_out,
   output int                       mismatch_count,
   output int                       pending_count
);

   typedef struct packed {
      status_type        status;
      logic [IF_W-1:0]   iface;
      logic [ADDR_W-1:0] gateway;
      logic [TTL_W-1:0]  ttl;
   } reply_type;

   logic            route_used [TABLE_ENTRIES];
   route_entry_type routes     [TABLE_ENTRIES];
   reply_type       awaited_replies [$];

   function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
      if (len == 0) return '0;
      return {ADDR_W{1'b1}} << (ADDR_W - len);
   endfunction

   // Applies one request word to the table copy and returns the reply it must produce.
   function automatic reply_type route_table_answer(
         input logic              op,
         input logic [ADDR_W-1:0] key,
         input logic [LEN_W-1:0]  len_raw,
         input logic              has_hop,
         input logic [ADDR_W-1:0] hop,
         input logic [IF_W-1:0]   iface,
         input logic [TTL_W-1:0]  ttl);
      reply_type         answer;
      int                len;
      int                free_slot;
      int                best;
      logic [ADDR_W-1:0] prefix;
      answer = '0;
      if (op == OP_ADD) begin
         len = (len_raw > LEN_MAX) ? int'(LEN_MAX) : int'(len_raw);
         prefix = key & prefix_mask(len);
         free_slot = -1;
         answer.status = STATUS_ADDED;
         // A duplicate wins over a full table, so the whole table is searched first.
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (route_used[i]) begin
               if (routes[i].prefix == prefix && routes[i].length == LEN_W'(len))
                  answer.status = STATUS_DUPLICATE;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (answer.status != STATUS_DUPLICATE) begin
            if (free_slot < 0) begin
               answer.status = STATUS_FULL;
            end else begin
               route_used[free_slot] = 1'b1;
               routes[free_slot] = '{prefix, LEN_W'(len), iface, has_hop ? hop : '0, !has_hop};
            end
         end
      end else if (ttl <= 1) begin
         answer.status = STATUS_TTL_DROP;
      end else begin
         best = -1;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (route_used[i] && (key & prefix_mask(routes[i].length)) == routes[i].prefix)
               if (best < 0 || routes[i].length > routes[best].length) best = i;
         end
         if (best < 0) begin
            answer.status = STATUS_NO_ROUTE;
         end else begin
            answer.status = STATUS_FORWARDED;
            answer.iface = routes[best].iface;
            answer.gateway = routes[best].direct ? key : routes[best].gateway;
            answer.ttl = ttl - 1'b1;
         end
      end
      return answer;
   endfunction

   task automatic note_mismatch(input string what);
      if (mismatch_count < 10) $display("%0t: %s", $realtime, what);
      mismatch_count <= mismatch_count + 1;
   endtask

   always @(posedge clock) begin
      reply_type wanted;
      if (reset) begin
         foreach (route_used[i]) route_used[i] = 1'b0;
         awaited_replies.delete();
         pending_count <= 0;
      end else begin
         // The result word is retired before a word taken at the same edge is predicted.
         if (rsp_strobe) begin
            if (awaited_replies.size() == 0) begin
               note_mismatch($sformatf("result word with none expected: status %0d",
                                       rsp_status));
            end else begin
               wanted = awaited_replies.pop_front();
               if (rsp_status !== wanted.status || rsp_out_interface !== wanted.iface ||
                   rsp_out_next_hop !== wanted.gateway || rsp_ttl_out !== wanted.ttl)
                  note_mismatch($sformatf(
                     "expected status %0d if %0d hop %h ttl %0d, got status %0d if %0d hop %h ttl %0d",
                     wanted.status, wanted.iface, wanted.gateway, wanted.ttl,
                     rsp_status, rsp_out_interface, rsp_out_next_hop, rsp_ttl_out));
            end
         end
         if (start && !busy)
            awaited_replies.push_back(route_table_answer(req_operation, req_key_address,
               req_prefix_length, req_has_next_hop, req_next_hop_address,
               req_interface_index, req_time_to_live));
         pending_count <= awaited_replies.size();
      end
   end

endmodule

`default_nettype wire

// File: tb/longest_prefix_match_router_core_test.sv
`default_nettype none

module longest_prefix_match_router_core_test;
   import lpmr_pkg::*;

   localparam int WORD_COUNT  = 400;
   localparam int CYCLE_LIMIT = 200000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_operation = OP_ADD;
   logic [ADDR_W-1:0]   req_key_address = '0;
   logic [LEN_W-1:0]    req_prefix_length = '0;
   logic                req_has_next_hop = 1'b0;
   logic [ADDR_W-1:0]   req_next_hop_address = '0;
   logic [IF_W-1:0]     req_interface_index = '0;
   logic [TTL_W-1:0]    req_time_to_live = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [IF_W-1:0]     rsp_out_interface;
   logic [ADDR_W-1:0]   rsp_out_next_hop;
   logic [TTL_W-1:0]    rsp_ttl_out;
   int                  mismatch_count;
   int                  pending_count;
   int                  cycle_count = 0;
   int                  idle_percent = 0;
   // The receiver cannot stall, so its phase is one more stretch without sender gaps.
   int                  idle_plan [4] = '{0, 46, 0, 29};
   logic [ADDR_W-1:0]   sent_keys [$];
   logic [LEN_W-1:0]    sent_lengths [$];

   longest_prefix_match_router_core i_dut (.*);

   longest_prefix_match_router_core_checker i_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Presents a word until taken, then leaves start high or drops it for an idle gap.
   task automatic send_word(
         input logic              op,
         input logic [ADDR_W-1:0] key,
         input logic [LEN_W-1:0]  len,
         input logic              has_hop,
         input logic [ADDR_W-1:0] hop,
         input logic [IF_W-1:0]   iface,
         input logic [TTL_W-1:0]  ttl);
      int gap;
      req_operation <= op;
      req_key_address <= key;
      req_prefix_length <= len;
      req_has_next_hop <= has_hop;
      req_next_hop_address <= hop;
      req_interface_index <= iface;
      req_time_to_live <= ttl;
      if (!start) start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op == OP_ADD) begin
         sent_keys.push_back(key);
         sent_lengths.push_back(len);
      end
      if ($urandom_range(0, 99) < idle_percent) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Most words are tied to earlier routes so that lookups hit and routes nest.
   task automatic random_word();
      logic [ADDR_W-1:0] key;
      logic [LEN_W-1:0]  len;
      logic [TTL_W-1:0]  ttl;
      logic              related;
      int                pick;
      pick = 0;
      related = sent_keys.size() > 0 && $urandom_range(0, 4) != 0;
      if (related) pick = $urandom_range(0, sent_keys.size() - 1);
      ttl = ($urandom_range(0, 9) == 0) ? TTL_W'($urandom_range(0, 1))
                                        : TTL_W'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 20) begin
         if (related && $urandom_range(0, 2) == 0) begin
            key = sent_keys[pick];
            len = sent_lengths[pick];
         end else begin
            key = related ? sent_keys[pick] ^ ($urandom >> $urandom_range(0, 32)) : $urandom;
            len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(33, 63))
                                              : LEN_W'($urandom_range(0, 32));
         end
         send_word(OP_ADD, key, len, 1'($urandom_range(0, 1)), $urandom,
                   IF_W'($urandom_range(0, 7)), ttl);
      end else begin
         key = related ? sent_keys[pick] ^ ($urandom >> $urandom_range(8, 32)) : $urandom;
         send_word(OP_ROUTE, key, LEN_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                   $urandom, IF_W'($urandom_range(0, 7)), ttl);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Lookups on the empty table.
      send_word(OP_ROUTE, 32'h0A01_0203, 6'd0,  1'b0, 32'h0, 3'd0, 8'd64);
      send_word(OP_ROUTE, 32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0, 3'd7, 8'd0);
      // A default route, nested routes, and duplicates by masking and by saturated length.
      send_word(OP_ADD,   32'hDEAD_BEEF, 6'd0,  1'b0, 32'hFFFF_FFFF, 3'd1, 8'd0);
      send_word(OP_ADD,   32'h0A00_0000, 6'd8,  1'b1, 32'hC0A8_0001, 3'd2, 8'd255);
      send_word(OP_ADD,   32'h0A01_0000, 6'd16, 1'b0, 32'h1234_5678, 3'd7, 8'd1);
      send_word(OP_ADD,   32'h0A01_0203, 6'd32, 1'b1, 32'hFFFF_FFFF, 3'd3, 8'd9);
      send_word(OP_ADD,   32'h0A01_0203, 6'd63, 1'b1, 32'h0000_0001, 3'd4, 8'd9);
      send_word(OP_ADD,   32'h0A01_6363, 6'd16, 1'b0, 32'h0, 3'd5, 8'd9);
      send_word(OP_ADD,   32'hFFFF_FFFF, 6'd40, 1'b1, 32'h0, 3'd0, 8'd9);
      send_word(OP_ADD,   32'h0000_0000, 6'd0,  1'b1, 32'h5555_AAAA, 3'd6, 8'd9);
      send_word(OP_ADD,   32'hFFFF_FFFF, 6'd1,  1'b1, 32'hAAAA_5555, 3'd5, 8'd9);
      // Lookups for each case of the TTL and of the longest match.
      send_word(OP_ROUTE, 32'h0A01_0203, 6'd0,  1'b0, 32'h0, 3'd0, 8'd255);
      send_word(OP_ROUTE, 32'h0A01_0505, 6'd63, 1'b1, 32'hFFFF_FFFF, 3'd7, 8'd2);
      send_word(OP_ROUTE, 32'h0A09_0909, 6'd0,  1'b0, 32'h0, 3'd0, 8'd1);
      send_word(OP_ROUTE, 32'h0A09_0909, 6'd0,  1'b0, 32'h0, 3'd0, 8'd3);
      send_word(OP_ROUTE, 32'h0B00_0000, 6'd0,  1'b0, 32'h0, 3'd0, 8'd0);
      send_word(OP_ROUTE, 32'hC801_0101, 6'd0,  1'b0, 32'h0, 3'd0, 8'd128);
      send_word(OP_ROUTE, 32'hFFFF_FFFF, 6'd0,  1'b0, 32'h0, 3'd0, 8'd255);
      send_word(OP_ROUTE, 32'hC000_0000, 6'd0,  1'b0, 32'h0, 3'd0, 8'd10);
      send_word(OP_ROUTE, 32'h0000_0000, 6'd0,  1'b0, 32'h0, 3'd0, 8'd2);

      foreach (idle_plan[p]) begin
         idle_percent = idle_plan[p];
         repeat (WORD_COUNT / 4) random_word();
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
